[sv/rgb565_bilinear_letterbox_scaler_macros.svh]
// ----------------------------------------------------------------------------
// RGB565 bilinear letterbox scaler - assertion macros
// Shared concurrent check forms, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB565_BILINEAR_LETTERBOX_SCALER_MACROS_SVH
`define RGB565_BILINEAR_LETTERBOX_SCALER_MACROS_SVH

// Same-cycle implication.
`define RBLS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbls same-cycle check failed");

// Next-cycle implication.
`define RBLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbls next-cycle check failed");

`endif

[sv/rbls_pkg.sv]
// ----------------------------------------------------------------------------
// rbls_pkg
// Types, sizes and constants shared by the scaler modules.
// ----------------------------------------------------------------------------
package rbls_pkg;

    localparam int SRC_MAX_W   = 256;
    localparam int SRC_MAX_H   = 256;
    localparam int PANEL_W     = 466;
    localparam int PANEL_H     = 466;
    localparam int FRAME_DEPTH = SRC_MAX_W * SRC_MAX_H;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int SX_W        = $clog2(SRC_MAX_W);
    localparam int SY_W        = $clog2(SRC_MAX_H);
    localparam int UX_W        = SX_W + 1;
    localparam int UY_W        = SY_W + 1;

    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 25;
    localparam int POS_W     = 9 + STEP_W;
    localparam int INT_LSB   = 16;
    localparam int IP_W      = POS_W - INT_LSB;
    localparam int FRAC_LSB  = 11;
    localparam int FRAC_W    = INT_LSB - FRAC_LSB;
    localparam int BLEND_SHIFT = 10;
    localparam int H_W       = 22;
    localparam int V_W       = 28;
    localparam int Q_DEPTH   = 2;

    localparam logic [15:0]       MASK_RB    = 16'hF81F;
    localparam logic [15:0]       MASK_G     = 16'h07E0;
    localparam logic [FRAC_W:0]   WEIGHT_ONE = 6'd32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_WINDOW_WIDTH  = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_WINDOW_LEFT   = 3'd4,
        CFG_WINDOW_TOP    = 3'd5,
        CFG_STEP_X        = 3'd6,
        CFG_STEP_Y        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        opcode;
        logic [8:0]  column;
        logic [8:0]  row;
        logic [15:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        in_window;
    } t_out_item;

    typedef struct packed {
        logic [8:0]        source_width;
        logic [8:0]        source_height;
        logic [8:0]        window_width;
        logic [8:0]        window_height;
        logic [8:0]        window_left;
        logic [8:0]        window_top;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
    } t_cfg;

    // Classified transaction: writes carry the saturated source index,
    // reads carry the offset inside the window.
    typedef struct packed {
        logic        opcode;
        logic        in_win;
        logic [8:0]  column;
        logic [8:0]  row;
        logic [15:0] pixel;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic idle;
        logic ram_we;
    } t_back_stat;

endpackage

[sv/rbls_ram.sv]
// ----------------------------------------------------------------------------
// rbls_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/rbls_front.sv]
// ----------------------------------------------------------------------------
// rbls_front
// Accept input transactions, saturate indices and classify reads against
// the window.
// ----------------------------------------------------------------------------
module rbls_front (
    input  logic               i_valid,
    input  rbls_pkg::t_in_item i_item,
    input  rbls_pkg::t_cfg     i_cfg,
    input  rbls_pkg::t_q_stat  i_q_stat,
    output logic               o_stall,
    output logic               o_push,
    output rbls_pkg::t_q_entry o_entry
);
    import rbls_pkg::*;

    logic [8:0] w_wcol, w_wrow, w_pcol, w_prow, w_offx, w_offy;
    logic       w_inside;

    always_comb begin
        w_wcol = (32'(i_item.column) > SRC_MAX_W - 1) ? 9'(SRC_MAX_W - 1) : i_item.column;
        w_wrow = (32'(i_item.row) > SRC_MAX_H - 1) ? 9'(SRC_MAX_H - 1) : i_item.row;
        w_pcol = (32'(i_item.column) > PANEL_W - 1) ? 9'(PANEL_W - 1) : i_item.column;
        w_prow = (32'(i_item.row) > PANEL_H - 1) ? 9'(PANEL_H - 1) : i_item.row;
        w_offx = w_pcol - i_cfg.window_left;
        w_offy = w_prow - i_cfg.window_top;
        w_inside = (w_pcol >= i_cfg.window_left) && (w_offx < i_cfg.window_width) &&
                   (w_prow >= i_cfg.window_top) && (w_offy < i_cfg.window_height);

        o_entry.opcode = i_item.opcode;
        o_entry.pixel  = i_item.pixel_in;
        if (i_item.opcode == OP_WRITE) begin
            o_entry.in_win = 1'b0;
            o_entry.column = w_wcol;
            o_entry.row    = w_wrow;
        end else begin
            o_entry.in_win = w_inside;
            o_entry.column = w_offx;
            o_entry.row    = w_offy;
        end
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;
endmodule

[sv/rbls_fifo.sv]
// ----------------------------------------------------------------------------
// rbls_fifo
// Short queue between the classifier and the execution back end.
// ----------------------------------------------------------------------------
module rbls_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rbls_pkg::t_q_entry i_entry,
    input  logic               i_pop,
    output rbls_pkg::t_q_entry o_head,
    output rbls_pkg::t_q_stat  o_stat
);
    import rbls_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_q_entry           r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == Q_DEPTH - 1) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (32'(r_rd) == Q_DEPTH - 1) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (32'(r_cnt) == Q_DEPTH);
    assign o_stat.empty = (r_cnt == '0);
endmodule

[sv/rbls_back.sv]
// ----------------------------------------------------------------------------
// rbls_back
// Execute queued transactions: store pixels, or locate, fetch and blend a
// 2x2 source neighborhood.
// ----------------------------------------------------------------------------
module rbls_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbls_pkg::t_cfg      i_cfg,
    input  rbls_pkg::t_q_entry  i_head,
    input  rbls_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output rbls_pkg::t_out_item o_data,
    output rbls_pkg::t_back_stat o_stat
);
    import rbls_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_LOC  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_BL1  = 7'b0010000,
        S_BL2  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    function automatic logic [ADDR_W-1:0] frame_addr(input logic [SX_W-1:0] x,
                                                     input logic [SY_W-1:0] y);
        frame_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(SRC_MAX_W)) + ADDR_W'(x);
    endfunction

    t_state              r_state, n_state;
    t_q_entry            r_cmd;
    logic [POS_W-1:0]    r_pos_x, r_pos_y;
    logic [ADDR_W-1:0]   r_addr [4];
    logic [FRAC_W-1:0]   r_fx, r_fy;
    logic [2:0]          r_rd_cnt;
    logic [15:0]         r_pix [4];
    logic [H_W-1:0]      r_t_rb, r_t_g, r_b_rb, r_b_g;
    t_out_item           r_out;

    logic [UX_W-1:0]     w_used_x, w_x0p1;
    logic [UY_W-1:0]     w_used_y, w_y0p1;
    logic [IP_W-1:0]     w_ip_x, w_ip_y;
    logic [SX_W-1:0]     w_x0, w_x1;
    logic [SY_W-1:0]     w_y0, w_y1;
    logic [FRAC_W:0]     w_ifx, w_ify;
    logic [V_W-1:0]      w_rb, w_g;
    logic [15:0]         w_blend;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [15:0]         w_rdata;

    // Clamp the used source size to 1..max.
    always_comb begin
        if (i_cfg.source_width == '0) begin
            w_used_x = UX_W'(1);
        end else if (32'(i_cfg.source_width) > SRC_MAX_W) begin
            w_used_x = UX_W'(SRC_MAX_W);
        end else begin
            w_used_x = UX_W'(i_cfg.source_width);
        end
        if (i_cfg.source_height == '0) begin
            w_used_y = UY_W'(1);
        end else if (32'(i_cfg.source_height) > SRC_MAX_H) begin
            w_used_y = UY_W'(SRC_MAX_H);
        end else begin
            w_used_y = UY_W'(i_cfg.source_height);
        end
    end

    // Integer part saturates at the last used column or row.
    always_comb begin
        w_ip_x = r_pos_x[POS_W-1:INT_LSB];
        w_ip_y = r_pos_y[POS_W-1:INT_LSB];
        w_x0   = (w_ip_x >= IP_W'(w_used_x)) ? SX_W'(w_used_x - UX_W'(1)) : SX_W'(w_ip_x);
        w_y0   = (w_ip_y >= IP_W'(w_used_y)) ? SY_W'(w_used_y - UY_W'(1)) : SY_W'(w_ip_y);
        w_x0p1 = UX_W'(w_x0) + UX_W'(1);
        w_y0p1 = UY_W'(w_y0) + UY_W'(1);
        w_x1   = (w_x0p1 < w_used_x) ? SX_W'(w_x0p1) : w_x0;
        w_y1   = (w_y0p1 < w_used_y) ? SY_W'(w_y0p1) : w_y0;
        w_ifx  = WEIGHT_ONE - {1'b0, r_fx};
        w_ify  = WEIGHT_ONE - {1'b0, r_fy};
        w_rb   = (V_W'(r_t_rb) * V_W'(w_ify) + V_W'(r_b_rb) * V_W'(r_fy)) >> BLEND_SHIFT;
        w_g    = (V_W'(r_t_g) * V_W'(w_ify) + V_W'(r_b_g) * V_W'(r_fy)) >> BLEND_SHIFT;
        w_blend = (w_rb[15:0] & MASK_RB) | (w_g[15:0] & MASK_G);
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_ram_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_head.opcode == OP_WRITE) begin
                        w_ram_we = 1'b1;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: n_state = S_LOC;
            S_LOC: n_state = S_RD;
            S_RD: begin
                if (r_rd_cnt == 3'd4) begin
                    n_state = S_BL1;
                end
            end
            S_BL1: n_state = S_BL2;
            S_BL2: n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RD) begin
                r_rd_cnt <= (r_rd_cnt == 3'd4) ? 3'd0 : r_rd_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_cmd <= i_head;
        end
        if (r_state == S_MUL) begin
            r_pos_x <= POS_W'(r_cmd.column) * POS_W'(i_cfg.step_x);
            r_pos_y <= POS_W'(r_cmd.row) * POS_W'(i_cfg.step_y);
        end
        if (r_state == S_LOC) begin
            r_fx <= r_pos_x[INT_LSB-1:FRAC_LSB];
            r_fy <= r_pos_y[INT_LSB-1:FRAC_LSB];
            if (r_cmd.in_win) begin
                r_addr[0] <= frame_addr(w_x0, w_y0);
                r_addr[1] <= frame_addr(w_x1, w_y0);
                r_addr[2] <= frame_addr(w_x0, w_y1);
                r_addr[3] <= frame_addr(w_x1, w_y1);
            end else begin
                r_addr[0] <= '0;
                r_addr[1] <= '0;
                r_addr[2] <= '0;
                r_addr[3] <= '0;
            end
        end
        if (r_state == S_RD && r_rd_cnt != 3'd0) begin
            r_pix[2'(r_rd_cnt - 3'd1)] <= w_rdata;
        end
        if (r_state == S_BL1) begin
            r_t_rb <= H_W'(r_pix[0] & MASK_RB) * H_W'(w_ifx) +
                      H_W'(r_pix[1] & MASK_RB) * H_W'(r_fx);
            r_t_g  <= H_W'(r_pix[0] & MASK_G) * H_W'(w_ifx) +
                      H_W'(r_pix[1] & MASK_G) * H_W'(r_fx);
            r_b_rb <= H_W'(r_pix[2] & MASK_RB) * H_W'(w_ifx) +
                      H_W'(r_pix[3] & MASK_RB) * H_W'(r_fx);
            r_b_g  <= H_W'(r_pix[2] & MASK_G) * H_W'(w_ifx) +
                      H_W'(r_pix[3] & MASK_G) * H_W'(r_fx);
        end
        if (r_state == S_BL2) begin
            r_out.in_window <= r_cmd.in_win;
            r_out.pixel_out <= r_cmd.in_win ? w_blend : r_pix[0];
        end
    end

    assign w_waddr = frame_addr(SX_W'(i_head.column), SY_W'(i_head.row));

    rbls_ram #(
        .WIDTH (16),
        .DEPTH (FRAME_DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (i_head.pixel),
        .i_raddr (r_addr[r_rd_cnt[1:0]]),
        .o_rdata (w_rdata)
    );

    assign o_valid       = (r_state == S_OUT);
    assign o_data        = r_out;
    assign o_stat.idle   = (r_state == S_IDLE);
    assign o_stat.ram_we = w_ram_we;
endmodule

[sv/rgb565_bilinear_letterbox_scaler.sv]
// ----------------------------------------------------------------------------
// rgb565_bilinear_letterbox_scaler
// Frame store plus bilinear RGB565 scaler that places the image in a window
// on the panel and fills the margin with source pixel (0,0).
// ----------------------------------------------------------------------------
// A write transaction (opcode 0) stores one RGB565 pixel in the frame memory
// and returns nothing; a read transaction (opcode 1) names a panel pixel and
// returns one pixel plus an in-window flag. Transactions complete in order.
// A write retires in the back end's idle state as it leaves the queue; a read
// leaves the queue and passes through multiply, locate, four fetches from the
// single read port of the frame RAM (whose read data is registered) and two
// blend stages before it shows its result, which then waits while stalled.
// The four sequential fetches through that one read port set the read rate.
// While a result waits, input is accepted until the two-entry queue is full.
// Configuration is taken at any edge with i_cfg_we high; change it only while
// the block is idle. Frame entries read before being written return garbage.
// ----------------------------------------------------------------------------
module rgb565_bilinear_letterbox_scaler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  rbls_pkg::t_in_item                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output rbls_pkg::t_out_item                 o_data,
    input  logic                                i_cfg_we,
    input  logic [rbls_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rbls_pkg::CFG_W-1:0]          i_cfg_data
);
    import rbls_pkg::*;

`include "rgb565_bilinear_letterbox_scaler_macros.svh"

    t_cfg       r_cfg;
    t_q_entry   w_entry, w_head;
    t_q_stat    w_q_stat;
    t_back_stat w_back_stat;
    logic       w_push, w_pop;

    // Configuration registers: hold until written, reset to the default
    // letterbox layout.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width  <= 9'd184;
            r_cfg.source_height <= 9'd224;
            r_cfg.window_width  <= 9'd276;
            r_cfg.window_height <= 9'd336;
            r_cfg.window_left   <= 9'd95;
            r_cfg.window_top    <= 9'd65;
            r_cfg.step_x        <= 25'd43690;
            r_cfg.step_y        <= 25'd43690;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_WIDTH:  r_cfg.source_width  <= i_cfg_data[8:0];
                CFG_SOURCE_HEIGHT: r_cfg.source_height <= i_cfg_data[8:0];
                CFG_WINDOW_WIDTH:  r_cfg.window_width  <= i_cfg_data[8:0];
                CFG_WINDOW_HEIGHT: r_cfg.window_height <= i_cfg_data[8:0];
                CFG_WINDOW_LEFT:   r_cfg.window_left   <= i_cfg_data[8:0];
                CFG_WINDOW_TOP:    r_cfg.window_top    <= i_cfg_data[8:0];
                CFG_STEP_X:        r_cfg.step_x        <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:        r_cfg.step_y        <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: saturate and classify each transaction, push into the queue.
    rbls_front u_front (
        .i_valid  (i_valid),
        .i_item   (i_data),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .o_stall  (o_stall),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    // Decoupling queue: lets the input side advance while a result stalls.
    rbls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back end: frame store writes, neighborhood fetch and blend.
    rbls_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .o_stat   (w_back_stat)
    );

    // Queue never takes a transaction while full.
    `RBLS_ASSERT_SAME(a_no_overflow, w_push, !w_q_stat.full)
    // A delivered result is never shown twice.
    `RBLS_ASSERT_NEXT(a_single_result, o_valid && !i_stall, !o_valid)
    // Frame writes happen only with the back end idle and no result pending.
    `RBLS_ASSERT_SAME(a_write_idle, w_back_stat.ram_we, w_back_stat.idle && !o_valid)
    // A pop always drains a non-empty queue.
    `RBLS_ASSERT_SAME(a_pop_nonempty, w_pop, !w_q_stat.empty)

endmodule
